// ===== rtl/core/sssd_pkg.sv =====
`timescale 1ns / 1ps

package sssd_pkg;

	localparam int NUM_POSITIONS = 8;
	localparam int POS_W = $clog2(NUM_POSITIONS);
	localparam int TEMP_W = 17;
	localparam int ALARM_W = 16;

	localparam logic [7:0] SEG_DP = 8'h80;
	localparam logic [7:0] SEG_C = 8'h39;
	localparam logic [7:0] SEG_DEG = 8'h63;
	localparam logic [7:0] SEG_OFF = 8'h00;
	localparam logic [TEMP_W-1:0] MAX_TEMP = 17'd99999;

	// Reciprocals for exact division of values below 100000
	localparam logic [17:0] RECIP10 = 18'd52429;     // shift 19
	localparam logic [17:0] RECIP100 = 18'd167773;   // shift 24
	localparam logic [17:0] RECIP1000 = 18'd134218;  // shift 27
	localparam logic [17:0] RECIP10000 = 18'd107375; // shift 30

	typedef enum logic [1:0] {
		MODE_TEMP = 2'd0,
		MODE_ALARM = 2'd1,
		MODE_SILENT = 2'd2,
		MODE_BLANK = 2'd3
	} mode_t;

	typedef enum logic {
		REG_MODE = 1'b0,
		REG_ALARM = 1'b1
	} reg_idx_t;

	// Load request after clamping, with its decimal quotients
	typedef struct packed {
		logic func;
		logic [TEMP_W-1:0] temp;
		logic [13:0] q10;
		logic [9:0] q100;
		logic [6:0] q1000;
		logic [3:0] q10000;
	} item_t;

	function automatic logic [13:0] div10(input logic [TEMP_W-1:0] x);
		logic [34:0] p;
		p = 35'(x) * 35'(RECIP10);
		return p[32:19];
	endfunction

	function automatic logic [9:0] div100(input logic [TEMP_W-1:0] x);
		logic [34:0] p;
		p = 35'(x) * 35'(RECIP100);
		return p[33:24];
	endfunction

	function automatic logic [6:0] div1000(input logic [TEMP_W-1:0] x);
		logic [34:0] p;
		p = 35'(x) * 35'(RECIP1000);
		return p[33:27];
	endfunction

	function automatic logic [3:0] div10000(input logic [TEMP_W-1:0] x);
		logic [34:0] p;
		p = 35'(x) * 35'(RECIP10000);
		return p[33:30];
	endfunction

	// x - 10*q, where q is floor(x/10); only the low digit survives
	function automatic logic [3:0] low_digit(input logic [TEMP_W-1:0] x,
			input logic [TEMP_W-1:0] q);
		logic [TEMP_W-1:0] diff;
		diff = x - TEMP_W'(q * TEMP_W'(10));
		return diff[3:0];
	endfunction

	function automatic logic [7:0] seg_code(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'd0: s = 8'h3f;
			4'd1: s = 8'h06;
			4'd2: s = 8'h5b;
			4'd3: s = 8'h4f;
			4'd4: s = 8'h66;
			4'd5: s = 8'h6d;
			4'd6: s = 8'h7d;
			4'd7: s = 8'h07;
			4'd8: s = 8'h7f;
			4'd9: s = 8'h6f;
			default: s = SEG_OFF;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/core/sssd_if.sv =====
`timescale 1ns / 1ps

interface sssd_in_if;
	logic valid;
	logic ready;
	logic func;
	logic signed [17:0] temperature_milli;
	modport source(output valid, func, temperature_milli, input ready);
	modport sink(input valid, func, temperature_milli, output ready);
endinterface

interface sssd_out_if;
	logic valid;
	logic ready;
	logic [sssd_pkg::POS_W-1:0] digit_select;
	logic [7:0] segments;
	logic scan_last;
	modport source(output valid, digit_select, segments, scan_last, input ready);
	modport sink(input valid, digit_select, segments, scan_last, output ready);
endinterface

interface sssd_cfg_if;
	logic valid;
	logic ready;
	logic index;
	logic [15:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/sssd_front.sv =====
`timescale 1ns / 1ps

module sssd_front (
	input logic clk,
	input logic arst_n,
	sssd_in_if.sink item,
	input logic advance,
	output logic valid_s1,
	output sssd_pkg::item_t item_s1
);

	logic [sssd_pkg::TEMP_W-1:0] temp_c;
	logic take;

	// Clamp negatives to zero, saturate at the display limit
	always_comb begin
		if (item.temperature_milli[17]) begin
			temp_c = '0;
		end else if (item.temperature_milli[16:0] > sssd_pkg::MAX_TEMP) begin
			temp_c = sssd_pkg::MAX_TEMP;
		end else begin
			temp_c = item.temperature_milli[16:0];
		end
	end

	assign item.ready = !valid_s1 || advance;
	assign take = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.func <= item.func;
			item_s1.temp <= temp_c;
			item_s1.q10 <= sssd_pkg::div10(temp_c);
			item_s1.q100 <= sssd_pkg::div100(temp_c);
			item_s1.q1000 <= sssd_pkg::div1000(temp_c);
			item_s1.q10000 <= sssd_pkg::div10000(temp_c);
		end
	end

endmodule

// ===== rtl/core/sssd_scan.sv =====
`timescale 1ns / 1ps

module sssd_scan (
	input logic clk,
	input logic arst_n,
	sssd_cfg_if.sink cfg,
	sssd_out_if.source result,
	input logic valid_s1,
	input sssd_pkg::item_t item_s1,
	output logic advance
);

	localparam logic [sssd_pkg::POS_W-1:0] LAST_POS =
		sssd_pkg::POS_W'(sssd_pkg::NUM_POSITIONS - 1);

	sssd_pkg::mode_t mode_q;
	logic [sssd_pkg::ALARM_W-1:0] alarm_value_q;
	logic [sssd_pkg::ALARM_W-1:0] alarm_rem_q;
	logic [sssd_pkg::POS_W-1:0] scan_pos_q;
	logic [7:0] disp_q [sssd_pkg::NUM_POSITIONS];

	logic out_free;
	logic do_load;
	logic do_scan;
	logic [sssd_pkg::ALARM_W-1:0] rem_src;
	logic [13:0] rem_quo;
	logic [3:0] rem_dig;
	logic [sssd_pkg::ALARM_W-1:0] rem_n;
	logic [7:0] seg_n;
	logic last_n;
	logic [sssd_pkg::POS_W-1:0] pos_n;
	logic [3:0] dig [5];

	assign cfg.ready = 1'b1;
	assign out_free = !result.valid || result.ready;
	assign advance = valid_s1 && (!item_s1.func || out_free);
	assign do_load = advance && !item_s1.func;
	assign do_scan = advance && item_s1.func;

	// Decimal digits of the loaded temperature, least significant first
	always_comb begin
		dig[0] = sssd_pkg::low_digit(item_s1.temp, 17'(item_s1.q10));
		dig[1] = sssd_pkg::low_digit(17'(item_s1.q10), 17'(item_s1.q100));
		dig[2] = sssd_pkg::low_digit(17'(item_s1.q100), 17'(item_s1.q1000));
		dig[3] = sssd_pkg::low_digit(17'(item_s1.q1000), 17'(item_s1.q10000));
		dig[4] = item_s1.q10000;
	end

	always_comb begin
		// Reload the alarm remainder at the start of every scan
		rem_src = (scan_pos_q == '0) ? alarm_value_q : alarm_rem_q;
		rem_quo = sssd_pkg::div10({1'b0, rem_src});
		rem_dig = sssd_pkg::low_digit({1'b0, rem_src}, 17'(rem_quo));
		rem_n = rem_src;
		last_n = (scan_pos_q == LAST_POS);
		case (mode_q)
			sssd_pkg::MODE_TEMP: begin
				seg_n = disp_q[scan_pos_q];
			end
			sssd_pkg::MODE_ALARM: begin
				if (scan_pos_q < sssd_pkg::POS_W'(2)) begin
					seg_n = disp_q[scan_pos_q];
				end else begin
					seg_n = sssd_pkg::seg_code(rem_dig);
					rem_n = sssd_pkg::ALARM_W'(rem_quo);
					if (rem_quo == '0) begin
						last_n = 1'b1;
					end
				end
			end
			sssd_pkg::MODE_SILENT: begin
				seg_n = sssd_pkg::SEG_DP;
			end
			default: begin
				seg_n = sssd_pkg::SEG_OFF;
			end
		endcase
		pos_n = last_n ? '0 : scan_pos_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sssd_pkg::MODE_TEMP;
			alarm_value_q <= 16'd45;
		end else if (cfg.valid) begin
			case (sssd_pkg::reg_idx_t'(cfg.index))
				sssd_pkg::REG_MODE: mode_q <= sssd_pkg::mode_t'(cfg.data[1:0]);
				sssd_pkg::REG_ALARM: alarm_value_q <= cfg.data;
				default: mode_q <= mode_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_pos_q <= '0;
			alarm_rem_q <= '0;
			disp_q[0] <= sssd_pkg::SEG_C;
			disp_q[1] <= sssd_pkg::SEG_DEG;
			for (int i = 2; i < sssd_pkg::NUM_POSITIONS; i++) begin
				disp_q[i] <= sssd_pkg::SEG_OFF;
			end
		end else begin
			if (do_scan) begin
				scan_pos_q <= pos_n;
				alarm_rem_q <= rem_n;
			end
			if (do_load) begin
				disp_q[7] <= sssd_pkg::SEG_OFF;
				disp_q[6] <= sssd_pkg::seg_code(dig[4]);
				disp_q[5] <= sssd_pkg::seg_code(dig[3]) | sssd_pkg::SEG_DP;
				disp_q[4] <= sssd_pkg::seg_code(dig[2]);
				disp_q[3] <= sssd_pkg::seg_code(dig[1]);
				disp_q[2] <= sssd_pkg::seg_code(dig[0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.valid <= 1'b0;
		end else if (do_scan) begin
			result.valid <= 1'b1;
		end else if (result.ready) begin
			result.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_scan) begin
			result.digit_select <= scan_pos_q;
			result.segments <= seg_n;
			result.scan_last <= last_n;
		end
	end

endmodule

// ===== rtl/core/seven_segment_scan_display_core.sv =====
`timescale 1ns / 1ps

// Scan driver for an eight-position seven-segment thermometer display.
// item: requests with func 0 load a temperature in thousandths of a degree
//   (negatives show as zero, values above 99.999 saturate); func 1 advances
//   the scan one position. A load gives no result; a scan request gives one.
// result: digit_select, segments (bit 7 decimal point, 6..0 g..a) and
//   scan_last, set on the position that ends the scan.
// cfg: index 0 sets the display mode, index 1 the alarm value. It is always
//   ready; write it only while no request is in flight.
// A scan request passes the input register, then the result register,
//   before it shows on result. One request is taken per cycle unless result
//   stalls; a load is visible to a scan request taken the very next cycle.
// The decimal split of a load uses reciprocal multiplies in the input stage;
//   the alarm digit uses one in the result stage.
// Reset: mode temperature, alarm value 45, scan at position 0, buffer shows
//   C and a degree mark with blank digits.
// When result stalls, the result register holds, the input register still
//   takes one more scan request (loads keep passing), then item.ready drops
//   until result drains.
module seven_segment_scan_display_core (
	input logic clk,
	input logic arst_n,
	sssd_in_if.sink item,
	sssd_out_if.source result,
	sssd_cfg_if.sink cfg
);

	logic valid_s1;
	sssd_pkg::item_t item_s1;
	logic advance;

	sssd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.advance(advance),
		.valid_s1(valid_s1),
		.item_s1(item_s1)
	);

	sssd_scan u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.result(result),
		.valid_s1(valid_s1),
		.item_s1(item_s1),
		.advance(advance)
	);

endmodule
